@@ rtl/core/shcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial hex chunk line parser package
// Shared event codes, parser state, result record and the chunk prefix.
// ----------------------------------------------------------------------------
package shcp_pkg;

  localparam int CMD_DEPTH_DEFAULT = 64;
  localparam logic [7:0] LIMIT_RESET = 8'd96;

  localparam logic [3:0] PREFIX_LEN = 4'd15;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_CMD_CHAR    = 4'd1,
    EV_LINE_END    = 4'd2,
    EV_LINE_DROP   = 4'd3,
    EV_STREAM_START = 4'd4,
    EV_DATA_BYTE   = 4'd5,
    EV_CHUNK_END   = 4'd6,
    EV_BAD_HEX     = 4'd7,
    EV_TOO_LONG    = 4'd8
  } ev_t;

  typedef struct packed {
    logic       stream_mode;
    logic       nibble_waiting;
    logic [3:0] high_nibble;
    logic [3:0] prefix_matched;
    logic [7:0] chunk_length;
  } parse_state_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic [7:0] count;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h46;
      4'd1:    c = 8'h49;
      4'd2:    c = 8'h4C;
      4'd3:    c = 8'h45;
      4'd4:    c = 8'h2C;
      4'd5:    c = 8'h50;
      4'd6:    c = 8'h55;
      4'd7:    c = 8'h54;
      4'd8:    c = 8'h2C;
      4'd9:    c = 8'h43;
      4'd10:   c = 8'h48;
      4'd11:   c = 8'h55;
      4'd12:   c = 8'h4E;
      4'd13:   c = 8'h4B;
      4'd14:   c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/shcp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial hex chunk line parser channels
// Valid/ready channels for received characters and parser results.
// ----------------------------------------------------------------------------
interface shcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface shcp_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] data;
  logic [7:0] count;

  modport source (output valid, output event_res, output data, output count, input ready);
  modport sink   (input valid, input event_res, input data, input count, output ready);
endinterface

@@ rtl/core/shcp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial hex chunk line parser step
// Decides the result and next state for one character from the current state.
// ----------------------------------------------------------------------------
module shcp_step
  import shcp_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT,
  localparam int CLW = $clog2(CMD_DEPTH)
) (
  input  logic [7:0]   c,
  input  logic [7:0]   limit,
  input  parse_state_t st,
  input  logic [CLW-1:0] cmd_len,
  output parse_state_t st_next,
  output logic [CLW-1:0] cmd_len_next,
  output result_t      res
);

  localparam logic [CLW-1:0] CMD_LAST = CLW'(CMD_DEPTH - 1);

  logic       nib_ok;
  logic [3:0] nib;
  logic [3:0] pm_next;
  logic       matched_all;
  logic [7:0] cl_inc;

  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      nib = 4'(c - CHAR_ZERO);
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      nib = 4'(c - CHAR_UA + 8'd10);
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      nib = 4'(c - CHAR_LA + 8'd10);
    end else begin
      nib_ok = 1'b0;
    end
  end

  always_comb begin
    matched_all = 1'b0;
    if (st.prefix_matched < PREFIX_LEN && c == prefix_char(st.prefix_matched)) begin
      pm_next = st.prefix_matched + 4'd1;
      matched_all = (pm_next == PREFIX_LEN);
    end else begin
      pm_next = (c == prefix_char(4'd0)) ? 4'd1 : 4'd0;
    end
  end

  assign cl_inc = st.chunk_length + 8'd1;

  always_comb begin
    st_next      = st;
    cmd_len_next = cmd_len;
    res.ev       = EV_NONE;
    res.data     = 8'd0;
    res.count    = 8'd0;
    if (st.stream_mode) begin
      if (c == CHAR_CR || c == CHAR_SPACE) begin
        res.ev = EV_NONE;
      end else if (c == CHAR_LF || !nib_ok) begin
        res.ev    = (c == CHAR_LF && !st.nibble_waiting) ? EV_CHUNK_END : EV_BAD_HEX;
        res.data  = (c == CHAR_LF) ? 8'd0 : c;
        res.count = st.chunk_length;
        st_next.stream_mode    = 1'b0;
        st_next.nibble_waiting = 1'b0;
        st_next.chunk_length   = 8'd0;
        st_next.prefix_matched = 4'd0;
        cmd_len_next           = '0;
      end else if (!st.nibble_waiting) begin
        st_next.nibble_waiting = 1'b1;
        st_next.high_nibble    = nib;
      end else begin
        st_next.nibble_waiting = 1'b0;
        res.data = {st.high_nibble, nib};
        if (st.chunk_length < limit) begin
          st_next.chunk_length = cl_inc;
          res.ev    = EV_DATA_BYTE;
          res.count = cl_inc;
        end else begin
          res.ev    = EV_TOO_LONG;
          res.count = st.chunk_length;
          st_next.stream_mode    = 1'b0;
          st_next.chunk_length   = 8'd0;
          st_next.prefix_matched = 4'd0;
          cmd_len_next           = '0;
        end
      end
    end else if (c == CHAR_CR) begin
      res.ev = EV_NONE;
    end else if (c == CHAR_LF) begin
      res.ev       = EV_LINE_END;
      res.count    = 8'(cmd_len);
      cmd_len_next = '0;
    end else begin
      st_next.prefix_matched = pm_next;
      if (matched_all) begin
        st_next.stream_mode    = 1'b1;
        st_next.nibble_waiting = 1'b0;
        st_next.chunk_length   = 8'd0;
        st_next.prefix_matched = 4'd0;
        cmd_len_next           = '0;
        res.ev   = EV_STREAM_START;
        res.data = c;
      end else if (cmd_len < CMD_LAST) begin
        res.ev       = EV_CMD_CHAR;
        res.data     = c;
        res.count    = 8'(cmd_len);
        cmd_len_next = cmd_len + 1'b1;
      end else begin
        res.ev       = EV_LINE_DROP;
        res.count    = 8'(CMD_LAST);
        cmd_len_next = '0;
      end
    end
  end

endmodule

@@ rtl/core/serial_hex_chunk_line_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial hex chunk line parser core
// Command line collection, chunk prefix detection and hex stream decoding.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                   | item
//  rx       | in  | rx_char[7:0]              | one received character
//  res      | out | event_res, data, count    | one result per character
//  cfg      | in  | cfg_wdata[7:0] on cfg_we  | chunk byte limit
//
// Each character passes through the input register and then the result
// register; one item is accepted every cycle while the result is not stalled.
// The parser state is updated when an item moves into the result register.
// A stalled result holds; the input register still takes one more item.
// Synchronous reset clears both registers, the state and sets the limit to 96.
// ----------------------------------------------------------------------------
module serial_hex_chunk_line_parser_core
  import shcp_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  shcp_rx_if.sink    rx,
  shcp_res_if.source res
);

  localparam int CLW = $clog2(CMD_DEPTH);

  logic           in_valid;
  logic [7:0]     in_char;
  logic           out_valid;
  result_t        out_res;
  logic [7:0]     limit;
  parse_state_t   st;
  parse_state_t   st_next;
  logic [CLW-1:0] cmd_len;
  logic [CLW-1:0] cmd_len_next;
  result_t        res_next;
  logic           advance;

  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  shcp_step #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_step (
    .c           (in_char),
    .limit       (limit),
    .st          (st),
    .cmd_len     (cmd_len),
    .st_next     (st_next),
    .cmd_len_next(cmd_len_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      limit     <= LIMIT_RESET;
      st        <= '0;
      cmd_len   <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
        cmd_len   <= cmd_len_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_char <= rx.rx_char;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign res.valid     = out_valid;
  assign res.event_res = out_res.ev;
  assign res.data      = out_res.data;
  assign res.count     = out_res.count;

  a_start_enters_stream: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.ev == EV_STREAM_START |=> st.stream_mode)
    else $error("stream start did not enter stream mode");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    st.prefix_matched < PREFIX_LEN)
    else $error("prefix match count out of range");

  a_no_nibble_in_cmd: assert property (@(posedge clk) disable iff (rst)
    !st.stream_mode |-> !st.nibble_waiting)
    else $error("nibble held in command mode");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.ev == EV_DATA_BYTE |-> out_res.count != 8'd0)
    else $error("data byte with zero count");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> rx.ready)
    else $error("empty input register not ready");

endmodule
